>>> hdl/bpsc_pkg.sv
// ----------------------------------------------------------------------------
// bpsc_pkg
// Shared types, constants and helpers for the byte pattern search unit.
// ----------------------------------------------------------------------------
package bpsc_pkg;

  // fixed field widths
  localparam int DATA_W        = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_PAT_WORDS = 4;
  localparam int PAT_LEN_W     = 6;
  localparam int CTX_LEN_W     = 5;

  // default sizing of the top level
  localparam int DEF_MAX_PATTERN = 32;
  localparam int DEF_MAX_CONTEXT = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTX_LEN   = 3'd5;

  // result kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_CHAR   = 2'd0;
  localparam kind_t KIND_EOL    = 2'd1;
  localparam kind_t KIND_STATUS = 2'd2;

  // character display range
  localparam logic [DATA_W-1:0] CHAR_PRINT_LO = 8'd32;
  localparam logic [DATA_W-1:0] CHAR_PRINT_HI = 8'd126;
  localparam logic [DATA_W-1:0] CHAR_SUBST    = 8'd63;

  // input word
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              end_of_file;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [DATA_W-1:0] out_char;
    kind_t             kind;
    logic              found;
    logic              last_of_run;
  } out_word_t;

  // source of the next result word
  typedef enum logic [1:0] {
    SEL_CHAR_MEM = 2'd0,
    SEL_CHAR_IN  = 2'd1,
    SEL_EOL      = 2'd2,
    SEL_STATUS   = 2'd3
  } out_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic     accept;
    logic     rd_en;
    logic     out_load;
    out_sel_e out_sel;
    logic     found;
    logic     last;
    logic     clear;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hit;
    logic ctx_zero;
    logic out_free;
  } dp_sts_t;

  // printable bytes pass, everything else shows as a question mark
  function automatic logic [DATA_W-1:0] shown_char(logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    r = (b >= CHAR_PRINT_LO && b <= CHAR_PRINT_HI) ? b : CHAR_SUBST;
    return r;
  endfunction

endpackage

>>> hdl/byte_pattern_search_with_context_unit.sv
// ----------------------------------------------------------------------------
// byte_pattern_search_with_context_unit
// Streams a file's bytes, finds the first occurrence of a configured pattern,
// prints it with context if a context length is set, reports found status.
// ----------------------------------------------------------------------------
// A byte that causes no result is accepted while the controller stays idle,
// so a file streams at one byte per clock until the first match. On that
// match, if context is set, the input stalls while the leading context and
// pattern bytes go out, each read in S_RD (history memory address), then
// sent in S_PUT (registered read data). Each trailing byte after the match
// is accepted, then sent as its character word from S_TRAIL; S_EOL adds the
// line end. The byte marked end of file is followed by its marker words:
// the line end of a still open line, then the status word. Output stalls
// stretch any of these. No clearing pass is needed after reset.
module byte_pattern_search_with_context_unit import bpsc_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int MAX_CONTEXT = DEF_MAX_CONTEXT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_data_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_data_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int WINDOW = MAX_PATTERN + MAX_CONTEXT;
  localparam int SEEN_W = $clog2(WINDOW + 1);
  localparam int CTX_W  = (MAX_CONTEXT > 0) ? $clog2(MAX_CONTEXT + 1) : 1;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [SEEN_W-1:0] cnt_init;
  logic [SEEN_W-1:0] rd_off;
  logic [CTX_W-1:0]  ctx;

  // controller
  bpsc_ctrl #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_CONTEXT(MAX_CONTEXT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .eof_i      (in_data_i.end_of_file),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cnt_init_i (cnt_init),
    .ctx_i      (ctx),
    .cmd_o      (cmd),
    .rd_off_o   (rd_off)
  );

  // datapath
  bpsc_dp #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_CONTEXT(MAX_CONTEXT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .data_byte_i (in_data_i.data_byte),
    .cmd_i       (cmd),
    .rd_off_i    (rd_off),
    .sts_o       (sts),
    .cnt_init_o  (cnt_init),
    .ctx_o       (ctx),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hdl/bpsc_dp.sv
// ----------------------------------------------------------------------------
// bpsc_dp
// Datapath: configuration registers, match window, history memory,
// byte counter and the result output register.
// ----------------------------------------------------------------------------
module bpsc_dp import bpsc_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int MAX_CONTEXT = DEF_MAX_CONTEXT,
  localparam int WINDOW = MAX_PATTERN + MAX_CONTEXT,
  localparam int SEEN_W = $clog2(WINDOW + 1),
  localparam int CTX_W  = (MAX_CONTEXT > 0) ? $clog2(MAX_CONTEXT + 1) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input byte
  input  logic [DATA_W-1:0]     data_byte_i,
  // control
  input  dp_cmd_t               cmd_i,
  input  logic [SEEN_W-1:0]     rd_off_i,
  output dp_sts_t               sts_o,
  output logic [SEEN_W-1:0]     cnt_init_o,
  output logic [CTX_W-1:0]      ctx_o,
  // result port
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_data_o
);

  localparam int PL_W  = $clog2(MAX_PATTERN + 1);
  localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DEPTH = 2 ** AW;
  localparam int PAT_W = MAX_PATTERN * DATA_W;

  // configuration registers
  logic [CFG_DATA_W-1:0] pat_word_q [NUM_PAT_WORDS];
  logic [PAT_LEN_W-1:0]  pat_len_q;
  logic [CTX_LEN_W-1:0]  ctx_len_q;

  // match window, history memory, counters
  logic [DATA_W-1:0]     win_q   [MAX_PATTERN];
  logic [DATA_W-1:0]     win_new [MAX_PATTERN];
  logic [DATA_W-1:0]     hist_mem [DEPTH];
  logic [AW-1:0]         wr_ptr_q;
  logic [AW-1:0]         rd_addr;
  logic [DATA_W-1:0]     rd_data_q;
  logic [SEEN_W-1:0]     seen_q;
  logic [SEEN_W-1:0]     seen_inc;

  // derived values
  logic [NUM_PAT_WORDS*CFG_DATA_W-1:0] pat_flat;
  logic [PAT_W-1:0]      pat_rev;
  logic [PAT_W-1:0]      pat_aligned;
  logic [PL_W-1:0]       plen;
  logic [PL_W-1:0]       shamt;
  logic [CTX_W-1:0]      ctx;
  logic [MAX_PATTERN-1:0] eq_vec;
  logic [SEEN_W-1:0]     avail;
  logic [SEEN_W-1:0]     ctx_ext;
  logic [SEEN_W-1:0]     pre;

  // output register
  logic                  out_valid_q;
  out_word_t             out_q;
  out_word_t             out_d;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_PAT_WORDS; w++) begin
        pat_word_q[w] <= '0;
      end
      pat_len_q <= '0;
      ctx_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAT_WORD0: pat_word_q[0] <= cfg_data_i;
        REG_PAT_WORD1: pat_word_q[1] <= cfg_data_i;
        REG_PAT_WORD2: pat_word_q[2] <= cfg_data_i;
        REG_PAT_WORD3: pat_word_q[3] <= cfg_data_i;
        REG_PAT_LEN:   pat_len_q     <= cfg_data_i[PAT_LEN_W-1:0];
        REG_CTX_LEN:   ctx_len_q     <= cfg_data_i[CTX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // capped lengths
  assign plen = (int'(pat_len_q) > MAX_PATTERN) ? PL_W'(MAX_PATTERN)
                                                 : pat_len_q[PL_W-1:0];
  assign ctx  = (int'(ctx_len_q) > MAX_CONTEXT) ? CTX_W'(MAX_CONTEXT)
                                                 : ctx_len_q[CTX_W-1:0];

  // pattern bytes reversed, then shifted so pattern byte plen-1 sits at tap 0
  assign pat_flat = {pat_word_q[3], pat_word_q[2], pat_word_q[1], pat_word_q[0]};
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat_rev[k*DATA_W +: DATA_W] = pat_flat[(MAX_PATTERN-1-k)*DATA_W +: DATA_W];
    end
  end
  assign shamt       = PL_W'(MAX_PATTERN) - plen;
  assign pat_aligned = pat_rev >> {shamt, 3'b000};

  // window as it stands after this byte
  always_comb begin
    win_new[0] = data_byte_i;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_new[j] = win_q[j-1];
    end
  end

  // per-tap compare against the aligned pattern
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      eq_vec[j] = (j >= plen) || (win_new[j] == pat_aligned[j*DATA_W +: DATA_W]);
    end
  end

  assign seen_inc = (seen_q == SEEN_W'(WINDOW)) ? seen_q : seen_q + SEEN_W'(1);

  // leading context clipped at start of file
  assign avail      = seen_inc - SEEN_W'(plen);
  assign ctx_ext    = SEEN_W'(ctx);
  assign pre        = (ctx_ext < avail) ? ctx_ext : avail;
  assign cnt_init_o = pre + SEEN_W'(plen);
  assign ctx_o      = ctx;

  assign sts_o.hit      = (plen != '0) && (seen_inc >= SEEN_W'(plen)) && (&eq_vec);
  assign sts_o.ctx_zero = (ctx == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // match window shift
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_q[j] <= win_new[j];
      end
    end
  end

  // byte counter, saturating, cleared at end of file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      wr_ptr_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        seen_q <= '0;
      end else if (cmd_i.accept) begin
        seen_q <= seen_inc;
      end
      if (cmd_i.accept) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
    end
  end

  // history memory, newest byte at wr_ptr - 1
  assign rd_addr = wr_ptr_q - rd_off_i[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hist_mem[wr_ptr_q] <= data_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  // next result word
  always_comb begin
    out_d = '0;
    out_d.last_of_run = cmd_i.last;
    unique case (cmd_i.out_sel)
      SEL_CHAR_MEM: begin
        out_d.out_char = shown_char(rd_data_q);
        out_d.kind     = KIND_CHAR;
      end
      SEL_CHAR_IN: begin
        out_d.out_char = shown_char(win_q[0]);
        out_d.kind     = KIND_CHAR;
      end
      SEL_EOL: begin
        out_d.kind = KIND_EOL;
      end
      SEL_STATUS: begin
        out_d.kind  = KIND_STATUS;
        out_d.found = cmd_i.found;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/bpsc_ctrl.sv
// ----------------------------------------------------------------------------
// bpsc_ctrl
// Controller: per-file match state and the sequencer that emits the
// context line, line end and status words.
// ----------------------------------------------------------------------------
module bpsc_ctrl import bpsc_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int MAX_CONTEXT = DEF_MAX_CONTEXT,
  localparam int WINDOW = MAX_PATTERN + MAX_CONTEXT,
  localparam int SEEN_W = $clog2(WINDOW + 1),
  localparam int CTX_W  = (MAX_CONTEXT > 0) ? $clog2(MAX_CONTEXT + 1) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              eof_i,
  output logic              in_ready_o,
  input  dp_sts_t           sts_i,
  input  logic [SEEN_W-1:0] cnt_init_i,
  input  logic [CTX_W-1:0]  ctx_i,
  output dp_cmd_t           cmd_o,
  output logic [SEEN_W-1:0] rd_off_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TRAIL = 6'b000010,
    S_EOL   = 6'b000100,
    S_RD    = 6'b001000,
    S_PUT   = 6'b010000,
    S_STAT  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic              match_seen_q, match_seen_d;
  logic              line_closed_q, line_closed_d;
  logic [CTX_W-1:0]  trail_q, trail_d;
  logic [SEEN_W-1:0] cnt_q, cnt_d;
  logic              eof_q, eof_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign rd_off_o   = cnt_q;

  // sequencer
  always_comb begin
    state_d       = state_q;
    match_seen_d  = match_seen_q;
    line_closed_d = line_closed_q;
    trail_d       = trail_q;
    cnt_d         = cnt_q;
    eof_d         = eof_q;
    cmd_o         = '0;
    cmd_o.out_sel = SEL_CHAR_MEM;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          eof_d        = eof_i;
          if (match_seen_q && !line_closed_q) begin
            // line open: one trailing byte, line end when count runs out
            if (trail_q != '0) begin
              trail_d       = trail_q - CTX_W'(1);
              line_closed_d = (trail_q == CTX_W'(1));
              state_d       = S_TRAIL;
            end else begin
              state_d = S_EOL;
            end
          end else if (!match_seen_q && sts_i.hit) begin
            // first match
            match_seen_d = 1'b1;
            if (sts_i.ctx_zero) begin
              line_closed_d = 1'b1;
              trail_d       = '0;
              state_d       = eof_i ? S_STAT : S_IDLE;
            end else begin
              cnt_d         = cnt_init_i;
              trail_d       = ctx_i;
              line_closed_d = 1'b0;
              state_d       = S_RD;
            end
          end else begin
            state_d = eof_i ? S_STAT : S_IDLE;
          end
        end
      end

      S_TRAIL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_CHAR_IN;
          cmd_o.last     = !(line_closed_q || eof_q);
          state_d        = (line_closed_q || eof_q) ? S_EOL : S_IDLE;
        end
      end

      S_EOL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_EOL;
          cmd_o.last     = !eof_q;
          line_closed_d  = 1'b1;
          state_d        = eof_q ? S_STAT : S_IDLE;
        end
      end

      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_PUT;
      end

      S_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_CHAR_MEM;
          cmd_o.last     = (cnt_q == SEEN_W'(1)) && !eof_q;
          cnt_d          = cnt_q - SEEN_W'(1);
          if (cnt_q == SEEN_W'(1)) begin
            state_d = eof_q ? S_EOL : S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end

      S_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_STATUS;
          cmd_o.found    = match_seen_q;
          cmd_o.last     = 1'b1;
          cmd_o.clear    = 1'b1;
          match_seen_d   = 1'b0;
          line_closed_d  = 1'b0;
          trail_d        = '0;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      match_seen_q  <= 1'b0;
      line_closed_q <= 1'b0;
      trail_q       <= '0;
      cnt_q         <= '0;
      eof_q         <= 1'b0;
    end else begin
      state_q       <= state_d;
      match_seen_q  <= match_seen_d;
      line_closed_q <= line_closed_d;
      trail_q       <= trail_d;
      cnt_q         <= cnt_d;
      eof_q         <= eof_d;
    end
  end

  // a result is only loaded when the output register can take it
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded into a full output register");

  // an open line always has trailing bytes left while waiting for input
  a_open_trail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && match_seen_q && !line_closed_q) |-> (trail_q != '0))
    else $error("open line with no trailing bytes left");

  // memory reads only while characters remain
  a_rd_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_PUT) |-> (cnt_q != '0))
    else $error("history read with empty count");

  // status word closes the file
  a_stat_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STAT && sts_i.out_free) |=> (!match_seen_q && state_q == S_IDLE))
    else $error("file state not cleared after status");

endmodule
